// ===== sv/life_generation_engine_macros.svh =====
// Assertion macros shared by the life generation engine RTL.
// Depends on nothing; the including module supplies clock and reset.
`ifndef LIFE_GENERATION_ENGINE_MACROS_SVH
`define LIFE_GENERATION_ENGINE_MACROS_SVH

// Check that a condition implies another in the same cycle
`define LGE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the following cycle
`define LGE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/lge_pkg.sv =====
// Shared types and constants of the life generation engine.
// Depends on nothing; used by the top level life_generation_engine.
package lge_pkg;

   localparam int OP_W    = 2;
   localparam int POS_W   = 6;
   localparam int SIDE_CW = 7;

   // Operation codes of an input item
   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

   localparam logic [SIDE_CW-1:0] GRID_SIDE_RESET = 7'd20;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [POS_W-1:0] cell_row;
      logic [POS_W-1:0] cell_col;
      logic             cell_value;
   } req_type;

   typedef struct packed {
      logic read_value;
      logic generation_done;
      logic position_error;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_APPLY,
      ST_STEP,
      ST_FINISH
   } state_type;

endpackage

// ===== sv/lge_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module lge_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write on enable, register the read and hold it otherwise
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== sv/lge_row_rule.sv =====
// B3/S23 rule applied to one grid row from the rows above and below it.
// Depends on nothing; instantiated by life_generation_engine.
module lge_row_rule #(
   parameter int MAX_SIDE = 64
) (
   input  logic [MAX_SIDE-1:0] upper,
   input  logic [MAX_SIDE-1:0] mid,
   input  logic [MAX_SIDE-1:0] lower,
   input  logic [MAX_SIDE-1:0] col_mask,
   output logic [MAX_SIDE-1:0] next_row
);

   logic [MAX_SIDE-1:0] up_m;
   logic [MAX_SIDE-1:0] mid_m;
   logic [MAX_SIDE-1:0] low_m;
   logic [MAX_SIDE-1:0] alive;

   // Drop columns beyond the side in use so they never count as neighbours
   assign up_m  = upper & col_mask;
   assign mid_m = mid & col_mask;
   assign low_m = lower & col_mask;

   for (genvar j = 0; j < MAX_SIDE; j++) begin : g_col
      logic l_up, l_mid, l_low, r_up, r_mid, r_low;
      logic [3:0] count;

      if (j > 0) begin : g_left
         assign l_up  = up_m[j-1];
         assign l_mid = mid_m[j-1];
         assign l_low = low_m[j-1];
      end else begin : g_left_edge
         assign l_up  = 1'b0;
         assign l_mid = 1'b0;
         assign l_low = 1'b0;
      end

      if (j < MAX_SIDE - 1) begin : g_right
         assign r_up  = up_m[j+1];
         assign r_mid = mid_m[j+1];
         assign r_low = low_m[j+1];
      end else begin : g_right_edge
         assign r_up  = 1'b0;
         assign r_mid = 1'b0;
         assign r_low = 1'b0;
      end

      // Count the eight neighbours, the cell itself excluded
      assign count = 4'(l_up) + 4'(up_m[j]) + 4'(r_up) + 4'(l_mid) + 4'(r_mid)
                   + 4'(l_low) + 4'(low_m[j]) + 4'(r_low);

      assign alive[j] = mid_m[j] ? (count == 4'd2 || count == 4'd3) : (count == 4'd3);
   end

   // Keep stored cells beyond the side unchanged
   assign next_row = (alive & col_mask) | (mid & ~col_mask);

endmodule

// ===== sv/life_generation_engine.sv =====
// Top level of the life generation engine: FSM, row memory and rule datapath.
// Depends on lge_pkg, lge_ram, lge_row_rule and life_generation_engine_macros.svh.
`include "life_generation_engine_macros.svh"

// The grid lives in a row memory, one word of MAX_SIDE cells per row. A cell
// write or read inside the grid fetches its row, then writes or reads it, going
// through the fetch, apply and finish states; an access outside the grid or an
// unused code goes from idle straight to finish. A generation step sweeps the
// rows in order, reading one row and writing back the row two before it in each
// cycle through a three-row window, then finishes; the single read and write
// port of the row memory sets that pace. One item is worked on at a time; the
// next item is taken while a finished result waits on the result side. Reset
// clears the grid at once through per-row valid bits, with no clearing pass.
// Write the side register only while no item is in flight.
module life_generation_engine #(
   parameter int MAX_SIDE = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  lge_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output lge_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lge_pkg::SIDE_CW-1:0]     csr_data
);

   localparam int ROW_W  = $clog2(MAX_SIDE);
   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int CNT_W  = $clog2(MAX_SIDE + 2);

   lge_pkg::state_type state_ff, state_in;
   lge_pkg::req_type   item_ff, item_in;
   lge_pkg::rsp_type   res_ff, res_in;
   lge_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [lge_pkg::SIDE_CW-1:0] grid_side_ff, grid_side_in;
   logic [SIDE_W-1:0]           side_use;
   logic [31:0]                 gs_ext, side32;

   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [31:0]         cnt32, wr_row32;
   logic [MAX_SIDE-1:0] upper_ff, upper_in, mid_ff, mid_in;
   logic [MAX_SIDE-1:0] lower_row, rule_row, col_mask, rd_row, mod_row;

   logic [MAX_SIDE-1:0] row_valid_ff, row_valid_in;
   logic                rd_valid_ff;

   logic                wr_en, rd_en;
   logic [ROW_W-1:0]    wr_addr, rd_addr;
   logic [MAX_SIDE-1:0] wr_data, rd_data;

   logic [31:0]         req_row32, req_col32, item_row32, item_col32;
   logic                req_in_grid;
   logic [ROW_W-1:0]    item_row, item_col;
   logic                slot_free;

   // Clamp the configured side into one to MAX_SIDE
   assign gs_ext = 32'(grid_side_ff);
   assign side32 = (gs_ext == 32'd0) ? 32'd1
                 : ((gs_ext > 32'(MAX_SIDE)) ? 32'(MAX_SIDE) : gs_ext);
   assign side_use = side32[SIDE_W-1:0];

   for (genvar j = 0; j < MAX_SIDE; j++) begin : g_mask
      assign col_mask[j] = (32'(j) < 32'(side_use));
   end

   // Position decode of the offered item and of the held item
   assign req_row32   = 32'(req_data.cell_row);
   assign req_col32   = 32'(req_data.cell_col);
   assign req_in_grid = (req_row32 < 32'(side_use)) && (req_col32 < 32'(side_use));
   assign item_row32  = 32'(item_ff.cell_row);
   assign item_col32  = 32'(item_ff.cell_col);
   assign item_row    = item_row32[ROW_W-1:0];
   assign item_col    = item_col32[ROW_W-1:0];

   assign cnt32    = 32'(cnt_ff);
   assign wr_row32 = cnt32 - 32'd2;

   // Rows never written since reset read as dead
   assign rd_row = rd_data & {MAX_SIDE{rd_valid_ff}};

   // Row below the one being rebuilt; dead once past the last row
   assign lower_row = (cnt32 >= 32'd1 && cnt32 <= 32'(side_use)) ? rd_row : '0;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != lge_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign grid_side_in = (csr_valid && csr_ready) ? csr_data : grid_side_ff;

   lge_ram #(
      .WIDTH (MAX_SIDE),
      .DEPTH (MAX_SIDE)
   ) u_rows (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lge_row_rule #(
      .MAX_SIDE (MAX_SIDE)
   ) u_rule (
      .upper    (upper_ff),
      .mid      (mid_ff),
      .lower    (lower_row),
      .col_mask (col_mask),
      .next_row (rule_row)
   );

   // Next state, memory control and result selection
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      res_in       = res_ff;
      cnt_in       = cnt_ff;
      upper_in     = upper_ff;
      mid_in       = mid_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      row_valid_in = row_valid_ff;
      wr_en        = 1'b0;
      wr_addr      = item_row;
      wr_data      = rule_row;
      rd_en        = 1'b0;
      rd_addr      = item_row;
      mod_row      = rd_row;
      mod_row[item_col] = item_ff.cell_value;

      unique case (state_ff)
         lge_pkg::ST_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               res_in  = '0;
               unique case (req_data.op) inside
                  lge_pkg::OP_WRITE, lge_pkg::OP_READ: begin
                     if (req_in_grid) begin
                        state_in = lge_pkg::ST_FETCH;
                     end else begin
                        res_in.position_error = 1'b1;
                        state_in = lge_pkg::ST_FINISH;
                     end
                  end
                  lge_pkg::OP_STEP: begin
                     cnt_in   = '0;
                     upper_in = '0;
                     mid_in   = '0;
                     state_in = lge_pkg::ST_STEP;
                  end
                  default: begin
                     state_in = lge_pkg::ST_FINISH;
                  end
               endcase
            end
         end
         lge_pkg::ST_FETCH: begin
            rd_en    = 1'b1;
            state_in = lge_pkg::ST_APPLY;
         end
         lge_pkg::ST_APPLY: begin
            if (item_ff.op == lge_pkg::OP_WRITE) begin
               wr_en   = 1'b1;
               wr_data = mod_row;
               row_valid_in[item_row] = 1'b1;
            end else begin
               res_in.read_value = rd_row[item_col];
            end
            state_in = lge_pkg::ST_FINISH;
         end
         lge_pkg::ST_STEP: begin
            // Read ahead one row, rebuild the row two behind the counter
            rd_en   = (cnt32 < 32'(side_use));
            rd_addr = cnt32[ROW_W-1:0];
            if (cnt32 >= 32'd1) begin
               upper_in = mid_ff;
               mid_in   = lower_row;
            end
            if (cnt32 >= 32'd2) begin
               wr_en   = 1'b1;
               wr_addr = wr_row32[ROW_W-1:0];
               wr_data = rule_row;
               row_valid_in[wr_row32[ROW_W-1:0]] = 1'b1;
            end
            if (cnt32 == 32'(side_use) + 32'd1) begin
               res_in.generation_done = 1'b1;
               state_in = lge_pkg::ST_FINISH;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         lge_pkg::ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = lge_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lge_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lge_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         row_valid_ff <= '0;
         grid_side_ff <= lge_pkg::GRID_SIDE_RESET;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         row_valid_ff <= row_valid_in;
         grid_side_ff <= grid_side_in;
         cnt_ff       <= cnt_in;
      end
   end

   // Payload registers; hold the row valid flag with the read data
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      res_ff      <= res_in;
      upper_ff    <= upper_in;
      mid_ff      <= mid_in;
      rsp_data_ff <= rsp_data_in;
      if (rd_en) begin
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
   end

   `LGE_ASSERT_NEXT(a_accept_leaves_idle, req_valid && !req_stall, state_ff != lge_pkg::ST_IDLE, "accepted item did not start")
   `LGE_ASSERT_SAME(a_no_rw_collision, wr_en && rd_en, wr_addr != rd_addr, "row read and write collide")
   `LGE_ASSERT_SAME(a_write_states, wr_en, state_ff == lge_pkg::ST_APPLY || state_ff == lge_pkg::ST_STEP, "row write outside apply or step")
   `LGE_ASSERT_SAME(a_single_flag, rsp_valid, !(rsp_data.generation_done && (rsp_data.read_value || rsp_data.position_error)), "inconsistent result flags")

endmodule
